// File: sv/cnsdo_pkg.sv
// Shared types and constants for the CANopen NMT slave with expedited SDO server.
// Holds the controller state type, the command/status bundles and the protocol codes.
// Used by cnsdo_ctrl, cnsdo_dp and canopen_nmt_sdo_server; depends on nothing.
`timescale 1ns / 1ps

package cnsdo_pkg;

   // NMT node modes as reported on nmt_state.
   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_PREOP = 2'd1;
   localparam logic [1:0] MODE_OP    = 2'd2;

   // NMT command specifiers.
   localparam logic [7:0] NMT_START      = 8'h01;
   localparam logic [7:0] NMT_STOP       = 8'h02;
   localparam logic [7:0] NMT_PREOP      = 8'h80;
   localparam logic [7:0] NMT_RESET_NODE = 8'h81;
   localparam logic [7:0] NMT_RESET_COMM = 8'h82;

   // SDO command specifiers and masks.
   localparam logic [7:0] SDO_CCS_MASK    = 8'hE0;
   localparam logic [7:0] SDO_CCS_DNLOAD  = 8'h20;
   localparam logic [7:0] SDO_CCS_UPLOAD  = 8'h40;
   localparam logic [7:0] SDO_SCS_DNLOAD  = 8'h60;
   localparam logic [7:0] SDO_SCS_UPLOAD  = 8'h43;
   localparam logic [7:0] SDO_SCS_ABORT   = 8'h80;
   localparam logic [31:0] SDO_ABORT_NOOBJ = 32'h0602_0000;

   // Identifiers.
   localparam logic [10:0] COB_NMT     = 11'h000;
   localparam logic [10:0] COB_SDO_RX  = 11'h600;
   localparam logic [10:0] COB_SDO_TX  = 11'h580;

   // Identity object entries loaded at initialization.
   localparam logic [15:0] ID_OBJECT   = 16'h1018;
   localparam logic [31:0] ID_PRODUCT  = 32'h1234_5678;
   localparam logic [31:0] ID_REVISION = 32'h0000_0100;
   localparam logic [2:0]  SIZE_BYTE   = 3'd1;
   localparam logic [2:0]  SIZE_WORD   = 3'd2;
   localparam logic [2:0]  SIZE_LONG   = 3'd4;
   localparam logic [1:0]  ID_LAST     = 2'd2;

   // One object dictionary entry.
   typedef struct packed {
      logic [2:0]  size;
      logic [31:0] value;
      logic [7:0]  sub;
      logic [15:0] obj;
   } entry_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic cfg_load;
      logic init_write;
      logic frame_load;
      logic nmt_apply;
      logic scan_start;
      logic scan_step;
      logic dl_write_hit;
      logic dl_write_new;
      logic out_load;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cfg_nonzero;
      logic init_last;
      logic is_nmt;
      logic is_dl;
      logic is_ul;
      logic table_full;
      logic scan_hit;
      logic scan_miss;
      logic out_full;
   } stat_type;

   // Keeps the low len bytes of a 32-bit value.
   function automatic logic [31:0] byte_mask(input logic [2:0] len);
      logic [31:0] m;
      case (len)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00FF;
         3'd2:    m = 32'h0000_FFFF;
         3'd3:    m = 32'h00FF_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

// File: sv/canopen_nmt_sdo_server.sv
// Path: NMT, foreign and unserved frames and a download into a full dictionary skip the
// dictionary scan; an SDO lookup reads entries up to the hit, or every entry in use on a
// miss, one entry per cycle.
// Throughput: one frame at a time; the next frame is taken once the result is registered,
// the controller is idle and no node ID write is pending; a result waits for a free result register.
// Reset (sync, active high): node ID 1, init mode, 3 identity entries written.
`timescale 1ns / 1ps

module canopen_nmt_sdo_server #(
   parameter int DICT_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Received CAN frames.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // rx_cob_id[10:0], rx_payload[74:11], zero pad
   // One result per frame.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // send_frame[0], tx_cob_id[11:1], tx_payload[75:12],
                                   // nmt_state[77:76], entries_used[82:78], zero pad
   // Node ID register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_wdata
);
   import cnsdo_pkg::*;

   ctl_type     ctl;
   stat_type    stat;
   logic        send_frame;
   logic [10:0] tx_cob_id;
   logic [63:0] tx_payload;
   logic [1:0]  nmt_state;
   logic [4:0]  entries_used;

   // The identity entries are rewritten after reset or after a nonzero node ID
   // write; frames wait until they are in place.
   // The controller owns all sequencing: the identity load, the decode step, the scan
   // over the dictionary and the hand-off into the result register.
   cnsdo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   // The datapath holds the frame, the node state, the dictionary memory and the
   // registered result beat. The result register lets the next frame enter while
   // the previous answer still waits for the consumer.
   cnsdo_dp #(
      .DICT_DEPTH (DICT_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .stat         (stat),
      .rx_cob_id    (req_tdata[10:0]),
      .rx_payload   (req_tdata[74:11]),
      .csr_wdata    (csr_wdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .send_frame   (send_frame),
      .tx_cob_id    (tx_cob_id),
      .tx_payload   (tx_payload),
      .nmt_state    (nmt_state),
      .entries_used (entries_used)
   );

   // Fields are packed from the lowest bit up; the unused top bits are zero.
   assign rsp_tdata = {5'd0, entries_used, nmt_state, tx_payload, tx_cob_id, send_frame};

endmodule

// File: sv/cnsdo_ctrl.sv
// Controller state machine of the CANopen NMT/SDO server.
// Sequences initialization, frame decode, dictionary scan and result hand-off.
// Depends on cnsdo_pkg.
`timescale 1ns / 1ps

module cnsdo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                rsp_tready,
   input  cnsdo_pkg::stat_type stat,
   output cnsdo_pkg::ctl_type  ctl
);
   import cnsdo_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      csr_ready  = 1'b0;
      case (state_ff)
         ST_INIT: begin
            ctl.init_write = 1'b1;
            if (stat.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            csr_ready  = 1'b1;
            req_tready = ~csr_valid;
            if (csr_valid) begin
               // A node ID of zero is dropped without effect.
               if (stat.cfg_nonzero) begin
                  ctl.cfg_load = 1'b1;
                  state_in     = ST_INIT;
               end
            end else if (req_tvalid) begin
               ctl.frame_load = 1'b1;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_nmt) begin
               ctl.nmt_apply = 1'b1;
               state_in      = ST_FINISH;
            end else if (stat.is_dl && stat.table_full) begin
               state_in = ST_FINISH;
            end else if (stat.is_dl || stat.is_ul) begin
               ctl.scan_start = 1'b1;
               state_in       = ST_SEARCH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SEARCH: begin
            ctl.scan_step = 1'b1;
            if (stat.scan_hit) begin
               ctl.dl_write_hit = stat.is_dl;
               state_in         = ST_FINISH;
            end else if (stat.scan_miss) begin
               ctl.dl_write_new = stat.is_dl;
               state_in         = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!stat.out_full || rsp_tready) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

// File: sv/cnsdo_dp.sv
// Datapath of the CANopen NMT/SDO server: frame register, node state, dictionary
// memory with its scan pointer, answer formatting and the result register.
// Depends on cnsdo_pkg; driven by cnsdo_ctrl.
`timescale 1ns / 1ps

module cnsdo_dp #(
   parameter int DICT_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cnsdo_pkg::ctl_type  ctl,
   output cnsdo_pkg::stat_type stat,
   input  logic [10:0]         rx_cob_id,
   input  logic [63:0]         rx_payload,
   input  logic [6:0]          csr_wdata,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic                send_frame,
   output logic [10:0]         tx_cob_id,
   output logic [63:0]         tx_payload,
   output logic [1:0]          nmt_state,
   output logic [4:0]          entries_used
);
   import cnsdo_pkg::*;

   localparam int AW = $clog2(DICT_DEPTH);
   localparam int CW = $clog2(DICT_DEPTH + 1);

   entry_type mem [DICT_DEPTH];

   logic [6:0]    node_ff;
   logic [1:0]    mode_ff;
   logic [CW-1:0] count_ff;
   logic [1:0]    init_idx_ff;
   logic [10:0]   cob_ff;
   logic [63:0]   pl_ff;
   logic [CW-1:0] scan_idx_ff;
   logic          rd_vld_ff;
   logic [AW-1:0] rd_idx_ff;
   entry_type     rd_data_ff;
   logic          hit_ff;
   entry_type     hit_data_ff;
   logic          rsp_valid_ff;
   logic          send_ff;
   logic [10:0]   tx_cob_ff;
   logic [63:0]   tx_pl_ff;
   logic [1:0]    state_out_ff;
   logic [4:0]    used_ff;

   logic [7:0]    sdo_cmd;
   logic [15:0]   sdo_obj;
   logic [7:0]    sdo_sub;
   logic [7:0]    nmt_cmd;
   logic [7:0]    nmt_target;
   logic          is_sdo;
   logic          match;
   logic          issue;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   entry_type     id_entry;
   logic [2:0]    dl_len;
   logic [2:0]    ul_len;
   logic [2:0]    ul_pad;
   logic          send_in;
   logic [63:0]   tx_pl_in;
   logic [CW+4:0] count_ext;

   assign sdo_cmd    = pl_ff[7:0];
   assign sdo_obj    = pl_ff[23:8];
   assign sdo_sub    = pl_ff[31:24];
   assign nmt_cmd    = pl_ff[7:0];
   assign nmt_target = pl_ff[15:8];
   assign is_sdo     = (cob_ff == (COB_SDO_RX + {4'd0, node_ff}));

   assign match = (rd_data_ff.obj == sdo_obj) && (rd_data_ff.sub == sdo_sub);
   assign issue = ctl.scan_step && (scan_idx_ff < count_ff);

   assign stat.cfg_nonzero = (csr_wdata != 7'd0);
   assign stat.init_last   = (init_idx_ff == ID_LAST);
   assign stat.is_nmt      = (cob_ff == COB_NMT);
   assign stat.is_dl       = is_sdo && ((sdo_cmd & SDO_CCS_MASK) == SDO_CCS_DNLOAD);
   assign stat.is_ul       = is_sdo && ((sdo_cmd & SDO_CCS_MASK) == SDO_CCS_UPLOAD);
   assign stat.table_full  = (count_ff >= CW'(DICT_DEPTH));
   assign stat.scan_hit    = rd_vld_ff && match;
   assign stat.scan_miss   = !rd_vld_ff && (scan_idx_ff >= count_ff);
   assign stat.out_full    = rsp_valid_ff;

   // Identity entries of object 0x1018, one per initialization cycle.
   always_comb begin
      id_entry.obj = ID_OBJECT;
      id_entry.sub = {6'd0, init_idx_ff} + 8'd1;
      case (init_idx_ff)
         2'd0: begin
            id_entry.value = {25'd0, node_ff};
            id_entry.size  = SIZE_BYTE;
         end
         2'd1: begin
            id_entry.value = ID_PRODUCT;
            id_entry.size  = SIZE_LONG;
         end
         default: begin
            id_entry.value = ID_REVISION;
            id_entry.size  = SIZE_WORD;
         end
      endcase
   end

   assign dl_len = 3'd4 - {1'b0, sdo_cmd[3:2]};

   always_comb begin
      mem_we    = ctl.init_write || ctl.dl_write_hit || ctl.dl_write_new;
      mem_waddr = rd_idx_ff;
      mem_wdata.obj   = sdo_obj;
      mem_wdata.sub   = sdo_sub;
      mem_wdata.value = pl_ff[63:32] & byte_mask(dl_len);
      mem_wdata.size  = dl_len;
      if (ctl.init_write) begin
         mem_waddr = AW'(init_idx_ff);
         mem_wdata = id_entry;
      end else if (ctl.dl_write_new) begin
         mem_waddr = count_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_idx_ff[AW-1:0]];
      rd_idx_ff  <= scan_idx_ff[AW-1:0];
   end

   // Node register, mode, entry count and scan control.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff     <= 7'd1;
         mode_ff     <= MODE_INIT;
         count_ff    <= CW'(3);
         init_idx_ff <= 2'd0;
         scan_idx_ff <= '0;
         rd_vld_ff   <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         if (ctl.cfg_load) begin
            node_ff     <= csr_wdata;
            mode_ff     <= MODE_INIT;
            count_ff    <= CW'(3);
            init_idx_ff <= 2'd0;
         end
         if (ctl.init_write) begin
            init_idx_ff <= init_idx_ff + 2'd1;
         end
         if (ctl.nmt_apply && (nmt_target == 8'd0 || nmt_target == {1'b0, node_ff})) begin
            case (nmt_cmd)
               NMT_START:      mode_ff <= MODE_OP;
               NMT_STOP:       mode_ff <= MODE_INIT;
               NMT_PREOP:      mode_ff <= MODE_PREOP;
               NMT_RESET_COMM: mode_ff <= MODE_PREOP;
               NMT_RESET_NODE: begin
                  mode_ff  <= MODE_INIT;
                  count_ff <= '0;
               end
               default: ;
            endcase
         end
         if (ctl.dl_write_new) begin
            count_ff <= count_ff + CW'(1);
         end
         if (ctl.scan_start) begin
            scan_idx_ff <= '0;
            rd_vld_ff   <= 1'b0;
            hit_ff      <= 1'b0;
         end else if (ctl.scan_step) begin
            rd_vld_ff <= issue;
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + CW'(1);
            end
            if (stat.scan_hit) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.frame_load) begin
         cob_ff <= rx_cob_id;
         pl_ff  <= rx_payload;
      end
      if (ctl.scan_step && stat.scan_hit) begin
         hit_data_ff <= rd_data_ff;
      end
   end

   // Answer formatting.
   assign ul_len = (hit_data_ff.size > 3'd4) ? 3'd4 : hit_data_ff.size;
   assign ul_pad = 3'd4 - ul_len;

   always_comb begin
      send_in  = 1'b0;
      tx_pl_in = '0;
      if (stat.is_dl) begin
         send_in  = 1'b1;
         tx_pl_in = {32'd0, sdo_sub, sdo_obj, SDO_SCS_DNLOAD};
      end else if (stat.is_ul) begin
         send_in = 1'b1;
         if (hit_ff) begin
            tx_pl_in = {hit_data_ff.value & byte_mask(ul_len), sdo_sub, sdo_obj,
                        SDO_SCS_UPLOAD | {3'd0, ul_pad, 2'd0}};
         end else begin
            tx_pl_in = {SDO_ABORT_NOOBJ, sdo_sub, sdo_obj, SDO_SCS_ABORT};
         end
      end
   end

   assign count_ext = {5'd0, count_ff};

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         send_ff      <= send_in;
         tx_cob_ff    <= send_in ? (COB_SDO_TX + {4'd0, node_ff}) : 11'd0;
         tx_pl_ff     <= tx_pl_in;
         state_out_ff <= mode_ff;
         used_ff      <= count_ext[4:0];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign send_frame   = send_ff;
   assign tx_cob_id    = tx_cob_ff;
   assign tx_payload   = tx_pl_ff;
   assign nmt_state    = state_out_ff;
   assign entries_used = used_ff;

endmodule
